/* hw/rtl/rllt_pkg.sv */
// ----------------------------------------------------------------------------
// rllt_pkg
// Shared codes and types of the run-length line table.
// ----------------------------------------------------------------------------
package rllt_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_ORDER   = 2'd1;
  localparam status_t ST_MISSING = 2'd2;
  localparam status_t ST_FULL    = 2'd3;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

endpackage

/* hw/rtl/rllt_run_mem.sv */
// ----------------------------------------------------------------------------
// rllt_run_mem
// Run storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rllt_run_mem #(
  parameter int DEPTH     = 256,
  parameter int ADDR_BITS = $clog2(DEPTH),
  parameter int WIDTH     = 33
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/run_length_line_table_core.sv */
// ----------------------------------------------------------------------------
// run_length_line_table_core
// Run-length table mapping instruction indices to source line numbers.
// ----------------------------------------------------------------------------
// For an append, the last run's line and count are mirrored in
// registers, so the table write happens in the accept cycle and the result
// beat is ready on the next one. A query walks the run memory from the cached
// cursor (or from run 0 when the index moved backwards), one run per cycle
// through the single read port, and reports a miss once no run is left to read.
// One item is in work at a time; a new beat is taken while the previous
// result is being popped. The run memory needs no clearing after reset.
module run_length_line_table_core #(
  parameter int MAX_RUNS   = 256,
  parameter int LINE_BITS  = 16,
  parameter int INDEX_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  op,
  input  logic [LINE_BITS-1:0]  line_number,
  input  logic [INDEX_BITS-1:0] instruction_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LINE_BITS-1:0]  line_out,
  output rllt_pkg::status_t     status
);

  import rllt_pkg::*;

  localparam int RUN_BITS  = $clog2(MAX_RUNS);
  localparam int CNT_BITS  = INDEX_BITS + 1;
  localparam int WORD_BITS = LINE_BITS + CNT_BITS;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic                  state;
  logic [RUN_BITS:0]     runs_used;
  logic [CNT_BITS-1:0]   recorded;
  logic [LINE_BITS-1:0]  tail_line;
  logic [CNT_BITS-1:0]   last_count;
  logic [RUN_BITS-1:0]   cursor_run;
  logic [INDEX_BITS-1:0] cursor_start;
  logic                  cursor_valid;
  logic [INDEX_BITS-1:0] query_idx;
  logic [RUN_BITS:0]     rd_run;
  logic [RUN_BITS-1:0]   eval_run;
  logic                  rd_pending;
  logic [CNT_BITS-1:0]   acc;

  logic                  accept;
  logic                  has_runs;
  logic                  rec_full;
  logic                  tbl_full;
  logic [RUN_BITS-1:0]   last_idx;
  logic                  do_extend;
  logic                  do_new;
  status_t               app_status;
  logic                  wr_en;
  logic [RUN_BITS-1:0]   wr_addr;
  logic [WORD_BITS-1:0]  wr_word;

  logic [WORD_BITS-1:0]  rd_word;
  logic [LINE_BITS-1:0]  rd_line;
  logic [CNT_BITS-1:0]   rd_count;
  logic [CNT_BITS-1:0]   sum;
  logic                  found;
  logic                  issue;
  logic                  walk_missing;
  logic                  from_cursor;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // append decision against the mirrored last run
  assign has_runs = (runs_used != '0);
  assign rec_full = recorded[CNT_BITS-1];
  assign tbl_full = (runs_used == (RUN_BITS+1)'(MAX_RUNS));
  assign last_idx = RUN_BITS'(runs_used - 1'b1);

  always_comb begin
    do_extend  = 1'b0;
    do_new     = 1'b0;
    app_status = ST_OK;
    if (rec_full) begin
      app_status = ST_FULL;
    end else if (has_runs && (line_number < tail_line)) begin
      app_status = ST_ORDER;
    end else if (has_runs && (line_number == tail_line)) begin
      do_extend = 1'b1;
    end else if (tbl_full) begin
      app_status = ST_FULL;
    end else begin
      do_new = 1'b1;
    end
  end

  assign wr_en   = accept && (op == OP_APPEND) && (do_extend || do_new);
  assign wr_addr = do_extend ? last_idx : runs_used[RUN_BITS-1:0];
  assign wr_word = do_extend ? {tail_line, last_count + 1'b1}
                             : {line_number, CNT_BITS'(1)};

  // walk: one read issued per cycle, evaluated the cycle after
  assign rd_line  = rd_word[WORD_BITS-1:CNT_BITS];
  assign rd_count = rd_word[CNT_BITS-1:0];
  assign sum      = acc + rd_count;
  assign found    = rd_pending && ({1'b0, query_idx} < sum);
  assign issue    = (state == S_WALK) && !found && (rd_run < runs_used);
  assign walk_missing = (state == S_WALK) && !rd_pending && (rd_run >= runs_used);
  assign from_cursor  = cursor_valid && (cursor_start <= instruction_index);

  rllt_run_mem #(
    .DEPTH    (MAX_RUNS),
    .ADDR_BITS(RUN_BITS),
    .WIDTH    (WORD_BITS)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_word),
    .rd_en  (issue),
    .rd_addr(rd_run[RUN_BITS-1:0]),
    .rd_data(rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      runs_used    <= '0;
      recorded     <= '0;
      cursor_run   <= '0;
      cursor_start <= '0;
      cursor_valid <= 1'b0;
      rd_pending   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // an append taken on the pop edge loads the next beat instead
      if (out_valid && out_ready && !(accept && (op == OP_APPEND))) begin
        out_valid <= 1'b0;
      end

      if (accept) begin
        if (op == OP_APPEND) begin
          out_valid <= 1'b1;
          line_out  <= '0;
          status    <= app_status;
          if (do_extend) begin
            last_count <= last_count + 1'b1;
            recorded   <= recorded + 1'b1;
          end else if (do_new) begin
            tail_line  <= line_number;
            last_count <= CNT_BITS'(1);
            runs_used  <= runs_used + 1'b1;
            recorded   <= recorded + 1'b1;
          end
        end else begin
          state      <= S_WALK;
          query_idx  <= instruction_index;
          rd_pending <= 1'b0;
          if (from_cursor) begin
            rd_run <= {1'b0, cursor_run};
            acc    <= {1'b0, cursor_start};
          end else begin
            rd_run <= '0;
            acc    <= '0;
          end
        end
      end

      if (state == S_WALK) begin
        rd_pending <= issue;
        if (issue) begin
          rd_run   <= rd_run + 1'b1;
          eval_run <= rd_run[RUN_BITS-1:0];
        end
        if (rd_pending && !found) begin
          acc <= sum;
        end
        if (found) begin
          state        <= S_IDLE;
          out_valid    <= 1'b1;
          line_out     <= rd_line;
          status       <= ST_OK;
          cursor_run   <= eval_run;
          cursor_start <= acc[INDEX_BITS-1:0];
          cursor_valid <= 1'b1;
        end else if (walk_missing) begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
          line_out  <= '0;
          status    <= ST_MISSING;
        end
      end
    end
  end

endmodule

/* hw/rtl/rllt_checker.sv */
// ----------------------------------------------------------------------------
// rllt_checker
// Port-level checks of the run-length line table, bound to the top level.
// ----------------------------------------------------------------------------
module rllt_checker #(
  parameter int LINE_BITS  = 16,
  parameter int INDEX_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  op,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [LINE_BITS-1:0]  line_out,
  input rllt_pkg::status_t     status
);

  import rllt_pkg::*;

  // no result beat straight out of reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat after reset");

  // failed items carry a zero line
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OK)) |-> (line_out == '0))
    else $error("nonzero line on failed item");

  // a held result blocks new beats
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result is held");

  // an append answers on the next cycle, never as not found
  a_append_next: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (op == OP_APPEND)) |=>
      (out_valid && (status != ST_MISSING) && (line_out == '0)))
    else $error("append result wrong or late");

  // a taken query closes the input as its walk starts
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (op == OP_QUERY)) |=> !in_ready)
    else $error("input open during query walk");

endmodule

bind run_length_line_table_core rllt_checker #(
  .LINE_BITS (LINE_BITS),
  .INDEX_BITS(INDEX_BITS)
) u_rllt_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .op               (op),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .line_out         (line_out),
  .status           (status)
);

/* bench/run_length_line_table_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// run_length_line_table_core_tb
// Self-checking bench for the run-length line table. A queue of appends and
// queries is built up front, driven with random gaps, and every result beat
// is compared with a shadow table that tracks runs, counts and the cursor.
// ----------------------------------------------------------------------------
module run_length_line_table_core_tb;
  import rllt_pkg::*;

  localparam int RUNS         = 256;
  localparam int INSN_SPACE   = 65536;
  localparam int RANDOM_ITEMS = 1030;
  localparam int TAIL_CYCLES  = 300;
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 4_000_000;

  typedef struct {
    logic        op;
    logic [15:0] line;
    logic [15:0] index;
    bit          burst;
  } line_req_t;

  typedef struct {
    logic [15:0] line;
    status_t     st;
  } line_ans_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        op = OP_APPEND;
  logic [15:0] line_number = '0;
  logic [15:0] instruction_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] line_out;
  status_t     status;

  run_length_line_table_core DUT (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .op                (op),
    .line_number       (line_number),
    .instruction_index (instruction_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .line_out          (line_out),
    .status            (status)
  );

  line_req_t req_q[$];
  line_ans_t answer_q[$];
  line_req_t next_req;
  line_ans_t want_ans;

  int n_items;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  int cycle_count = 0;
  bit in_taken = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  bit long_hold_done = 1'b0;

  // shadow of the run table, advanced on every accepted beat
  logic [15:0] tab_line [RUNS];
  int          tab_count [RUNS];
  int          tab_runs = 0;
  int          tab_total = 0;
  int          cur_run = 0;
  int          cur_start = 0;
  bit          cur_valid = 1'b0;

  // stimulus-side view of the table, used only to shape well-formed items
  logic [15:0] gen_last = '0;
  int          gen_runs = 0;
  int          gen_total = 0;
  int          gen_first [RUNS];

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int g;
    g = $urandom_range(0, 99);
    if (g < 60) return 0;
    if (g < 88) return $urandom_range(1, 3);
    if (g < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic void push_req(logic o, logic [15:0] ln, logic [15:0] ix, bit burst);
    line_req_t r;
    r.op    = o;
    r.line  = ln;
    r.index = ix;
    r.burst = burst;
    req_q.insert(req_q.size(), r);
  endfunction

  function automatic void gen_append(logic [15:0] ln, bit burst);
    push_req(OP_APPEND, ln, 16'($urandom_range(0, 65535)), burst);
    if (gen_total >= INSN_SPACE) return;
    if (gen_runs == 0 || ln > gen_last) begin
      if (gen_runs >= RUNS) return;
      gen_first[gen_runs] = gen_total;
      gen_runs++;
      gen_last = ln;
      gen_total++;
    end else if (ln == gen_last) begin
      gen_total++;
    end
  endfunction

  function automatic void gen_query(int ix, bit burst);
    if (ix > 65535) ix = 65535;
    push_req(OP_QUERY, 16'($urandom_range(0, 65535)), 16'(ix), burst);
  endfunction

  task automatic predict_entry(input logic o, input logic [15:0] ln, input logic [15:0] ix);
    line_ans_t a;
    int q_idx;
    int r;
    int acc;
    bit hit;
    q_idx  = int'(ix);
    a.line = '0;
    a.st   = ST_OK;
    if (o == OP_APPEND) begin
      if (tab_total >= INSN_SPACE) begin
        a.st = ST_FULL;
      end else if (tab_runs == 0) begin
        tab_line[0]  = ln;
        tab_count[0] = 1;
        tab_runs     = 1;
        tab_total++;
      end else if (ln < tab_line[tab_runs-1]) begin
        a.st = ST_ORDER;
      end else if (ln == tab_line[tab_runs-1]) begin
        tab_count[tab_runs-1]++;
        tab_total++;
      end else if (tab_runs >= RUNS) begin
        a.st = ST_FULL;
      end else begin
        tab_line[tab_runs]  = ln;
        tab_count[tab_runs] = 1;
        tab_runs++;
        tab_total++;
      end
    end else if (cur_valid && q_idx == cur_start && cur_run < tab_runs) begin
      a.line = tab_line[cur_run];
    end else begin
      // resume from the cached run unless the index moved backwards
      if (cur_valid && cur_start <= q_idx) begin
        r   = cur_run;
        acc = cur_start;
      end else begin
        r   = 0;
        acc = 0;
      end
      hit = 1'b0;
      while (!hit && r < tab_runs) begin
        acc += tab_count[r];
        if (q_idx < acc) begin
          hit       = 1'b1;
          cur_run   = r;
          cur_start = acc - tab_count[r];
          cur_valid = 1'b1;
          a.line    = tab_line[r];
        end else begin
          r++;
        end
      end
      if (!hit) a.st = ST_MISSING;
    end
    answer_q.insert(answer_q.size(), a);
  endtask

  // sender: one beat in flight, new payload only after the last one was taken
  always @(negedge clk) begin
    if (!rst && !(in_valid && !in_taken)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (req_q.size() > 0) begin
        next_req = req_q.pop_front();
        op                <= next_req.op;
        line_number       <= next_req.line;
        instruction_index <= next_req.index;
        in_valid          <= 1'b1;
        send_gap          <= next_req.burst ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back up the input
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (!long_hold_done && n_checked >= 200) begin
      long_hold_done <= 1'b1;
      stall_left     <= LONG_HOLD;
      out_ready      <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 99) < 12) begin
      stall_left <= pick_gap();
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    in_taken <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      predict_entry(op, line_number, instruction_index);
      n_accepted <= n_accepted + 1;
    end
    if (!rst && out_valid && out_ready) begin
      n_checked <= n_checked + 1;
      if (answer_q.size() == 0) begin
        $error("result beat with nothing pending: line_out %0d status %0d", line_out, status);
        n_errors++;
      end else begin
        want_ans = answer_q.pop_front();
        if (line_out !== want_ans.line) begin
          $error("line_out mismatch: expected %0d, actual %0d", want_ans.line, line_out);
          n_errors++;
        end
        if (status !== want_ans.st) begin
          $error("status mismatch: expected %0d, actual %0d", want_ans.st, status);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int pick;
    int q;
    int ix;
    int r;
    logic [15:0] ln;
    bit quiet;

    // empty table, run growth, order error, repeated and backward lookups
    gen_query(0, 0);
    gen_query(65535, 0);
    gen_append(16'd0, 0);
    gen_append(16'd0, 0);
    gen_query(1, 0);
    gen_query(0, 0);
    gen_append(16'd10, 0);
    gen_append(16'd4, 0);
    gen_query(2, 0);
    gen_query(2, 0);
    gen_query(1, 0);
    gen_query(3, 0);
    gen_append(16'd10, 0);
    gen_query(3, 0);
    gen_query(16'hAAAA, 0);
    gen_query(16'h5555, 0);
    gen_append(16'd12, 0);
    gen_query(4, 0);

    quiet = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        if (gen_runs < RUNS && $urandom_range(0, 99) < 65) begin
          if ($urandom_range(0, 19) == 0) ln = gen_last + 16'($urandom_range(21, 200));
          else ln = gen_last + 16'($urandom_range(1, 20));
        end else if (gen_runs == RUNS && $urandom_range(0, 3) == 0) begin
          ln = 16'($urandom_range(int'(gen_last) + 1, 65535));
        end else begin
          ln = gen_last;
        end
        gen_append(ln, quiet);
      end else if (pick < 50) begin
        // out-of-order noise; full-range lines only once runs are exhausted
        if (gen_runs == RUNS) ln = 16'($urandom_range(0, 65535));
        else if (gen_last > 0) ln = 16'($urandom_range(0, int'(gen_last) - 1));
        else ln = gen_last;
        gen_append(ln, quiet);
      end else begin
        q = $urandom_range(0, 99);
        if (q < 25) begin
          ix = int'(req_q[req_q.size()-1].index) + $urandom_range(0, 3);
          gen_query(ix, quiet);
        end else if (q < 40) begin
          r = $urandom_range(0, gen_runs - 1);
          gen_query(gen_first[r], quiet);
          if ($urandom_range(0, 1) == 1) gen_query(gen_first[r], quiet);
        end else if (q < 65) begin
          gen_query($urandom_range(0, gen_total - 1), quiet);
        end else if (q < 78) begin
          gen_query(gen_total + $urandom_range(0, 40), quiet);
        end else if (q < 90) begin
          gen_query($urandom_range(0, 65535), quiet);
        end else begin
          gen_query(($urandom_range(0, 1) == 1) ? gen_total - 1 : 0, quiet);
        end
      end
    end

    // make sure the run table is exhausted, then poke it
    while (gen_runs < RUNS) gen_append(gen_last + 16'd1, 0);
    gen_append(16'hFFFF, 0);
    gen_append(gen_last, 0);
    gen_query(gen_total - 1, 0);
    gen_query(0, 0);
    gen_query(gen_first[RUNS-1], 0);
    gen_query(gen_first[RUNS-1], 0);
    gen_query(gen_total, 0);

    n_items = req_q.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (n_accepted >= n_items);
    wait (n_checked >= n_items);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (answer_q.size() != 0) begin
      $error("%0d results never arrived", answer_q.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
